@@ hdl/pwf_pkg.sv @@
// Shared constants, codes and types of the password line input filter.
package pwf_pkg;

   localparam int MAX_LEN    = 32;
   localparam int MAX_PARAMS = 8;
   localparam int ADDR_W     = $clog2(MAX_LEN);
   localparam int LEN_W      = 6;
   localparam int PCNT_W     = $clog2(MAX_PARAMS);
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W     = $clog2(QUEUE_DEPTH);

   // Result kinds.
   localparam logic [2:0] KIND_NONE  = 3'd0;
   localparam logic [2:0] KIND_STAR  = 3'd1;
   localparam logic [2:0] KIND_ERASE = 3'd2;
   localparam logic [2:0] KIND_BYTE  = 3'd3;
   localparam logic [2:0] KIND_END   = 3'd4;

   // Escape recognizer states.
   localparam logic [1:0] ESC_NORMAL  = 2'd0;
   localparam logic [1:0] ESC_ESCAPED = 2'd1;
   localparam logic [1:0] ESC_SQUARE  = 2'd2;
   localparam logic [1:0] ESC_PARAMS  = 2'd3;

   // Commands from the front part to the back part.
   localparam logic [1:0] OP_NONE  = 2'd0;
   localparam logic [1:0] OP_ERASE = 2'd1;
   localparam logic [1:0] OP_STORE = 2'd2;
   localparam logic [1:0] OP_FLUSH = 2'd3;

   // Special bytes.
   localparam logic [7:0] CH_NEWLINE = 8'h0A;
   localparam logic [7:0] CH_BS      = 8'h08;
   localparam logic [7:0] CH_DEL     = 8'h7F;
   localparam logic [7:0] CH_ESC     = 8'h1B;
   localparam logic [7:0] CH_LBRACK  = 8'h5B;
   localparam logic [7:0] CH_QUEST   = 8'h3F;
   localparam logic [7:0] CH_SEMI    = 8'h3B;
   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_NINE    = 8'h39;
   localparam logic [7:0] CH_PRINT_LO = 8'h21;
   localparam logic [7:0] CH_PRINT_HI = 8'h7E;

   typedef struct packed {
      logic [1:0] op;
      logic [7:0] data;
   } cmd_type;

endpackage

@@ hdl/pwf_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module pwf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/pwf_front.sv @@
// Front part: accepts bytes, tracks escape sequences, issues commands.
module pwf_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [7:0]       req_in_byte,
   input  logic             queue_full,
   output logic             cmd_push,
   output pwf_pkg::cmd_type cmd
);

   logic [1:0]                 esc_ff, esc_in;
   logic [pwf_pkg::PCNT_W-1:0] pcnt_ff, pcnt_in;
   logic [pwf_pkg::PCNT_W-1:0] pcnt_eff;
   logic                       is_digit;
   logic                       sep_ok;

   assign req_stall = queue_full;
   assign cmd_push  = req_valid && !queue_full;

   assign is_digit = req_in_byte inside {[pwf_pkg::CH_ZERO:pwf_pkg::CH_NINE]};
   assign pcnt_eff = (esc_ff == pwf_pkg::ESC_SQUARE) ? '0 : pcnt_ff;
   assign sep_ok   = (req_in_byte == pwf_pkg::CH_SEMI) &&
                     (pcnt_eff < pwf_pkg::PCNT_W'(pwf_pkg::MAX_PARAMS - 1));

   always_comb begin
      esc_in    = esc_ff;
      pcnt_in   = pcnt_ff;
      cmd.op    = pwf_pkg::OP_NONE;
      cmd.data  = req_in_byte;
      if (req_in_byte == pwf_pkg::CH_NEWLINE) begin
         cmd.op  = pwf_pkg::OP_FLUSH;
         esc_in  = pwf_pkg::ESC_NORMAL;
         pcnt_in = '0;
      end else if (esc_ff == pwf_pkg::ESC_ESCAPED) begin
         esc_in = (req_in_byte == pwf_pkg::CH_LBRACK) ? pwf_pkg::ESC_SQUARE
                                                      : pwf_pkg::ESC_NORMAL;
      end else if (esc_ff == pwf_pkg::ESC_SQUARE && req_in_byte == pwf_pkg::CH_QUEST) begin
         esc_in  = pwf_pkg::ESC_PARAMS;
         pcnt_in = '0;
      end else if (esc_ff != pwf_pkg::ESC_NORMAL) begin
         // Parameter bytes; a square bracket opens with count zero.
         pcnt_in = pcnt_eff;
         if (sep_ok) begin
            esc_in  = pwf_pkg::ESC_PARAMS;
            pcnt_in = pcnt_eff + pwf_pkg::PCNT_W'(1);
         end else if (is_digit) begin
            esc_in = pwf_pkg::ESC_PARAMS;
         end else begin
            esc_in = pwf_pkg::ESC_NORMAL;
         end
      end else if (req_in_byte == pwf_pkg::CH_BS || req_in_byte == pwf_pkg::CH_DEL) begin
         cmd.op = pwf_pkg::OP_ERASE;
      end else if (req_in_byte == pwf_pkg::CH_ESC) begin
         esc_in = pwf_pkg::ESC_ESCAPED;
      end else if (req_in_byte inside {[pwf_pkg::CH_PRINT_LO:pwf_pkg::CH_PRINT_HI]}) begin
         cmd.op = pwf_pkg::OP_STORE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         esc_ff  <= pwf_pkg::ESC_NORMAL;
         pcnt_ff <= '0;
      end else if (cmd_push) begin
         esc_ff  <= esc_in;
         pcnt_ff <= pcnt_in;
      end
   end

endmodule

@@ hdl/pwf_queue.sv @@
// Short command queue between the front and back parts.
module pwf_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  pwf_pkg::cmd_type push_cmd,
   output logic             full,
   input  logic             pop,
   output logic             empty,
   output pwf_pkg::cmd_type pop_cmd
);

   localparam int CNT_W = $clog2(pwf_pkg::QUEUE_DEPTH + 1);

   pwf_pkg::cmd_type           entry_ff [pwf_pkg::QUEUE_DEPTH];
   logic [pwf_pkg::QPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]           count_ff, count_in;

   assign full    = (count_ff == CNT_W'(pwf_pkg::QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign pop_cmd = entry_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == pwf_pkg::QPTR_W'(pwf_pkg::QUEUE_DEPTH - 1))
                         ? '0 : wr_ptr_ff + pwf_pkg::QPTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == pwf_pkg::QPTR_W'(pwf_pkg::QUEUE_DEPTH - 1))
                         ? '0 : rd_ptr_ff + pwf_pkg::QPTR_W'(1);
         end
      end
   end

endmodule

@@ hdl/pwf_back.sv @@
// Back part: line buffer, fill count, flush sequencer and result register.
module pwf_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             queue_empty,
   input  pwf_pkg::cmd_type cmd,
   output logic             cmd_pop,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [2:0]       rsp_kind,
   output logic [7:0]       rsp_data_byte,
   output logic [5:0]       rsp_length,
   output logic             rsp_last
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_READ = 2'd1;
   localparam logic [1:0] ST_WAIT = 2'd2;
   localparam logic [1:0] ST_END  = 2'd3;

   logic [1:0]                 state_ff, state_in;
   logic [pwf_pkg::LEN_W-1:0]  fill_ff, fill_in;
   logic [pwf_pkg::LEN_W-1:0]  flush_len_ff, flush_len_in;
   logic [pwf_pkg::ADDR_W-1:0] idx_ff, idx_in;

   logic                       out_valid_ff;
   logic [2:0]                 out_kind_ff, out_kind_in;
   logic [7:0]                 out_data_ff, out_data_in;
   logic [pwf_pkg::LEN_W-1:0]  out_len_ff, out_len_in;
   logic                       out_last_ff, out_last_in;
   logic                       out_load;
   logic                       out_free;

   logic                       wr_en;
   logic                       rd_en;
   logic [7:0]                 rd_data;

   assign out_free = !out_valid_ff || !rsp_stall;
   assign cmd_pop  = (state_ff == ST_IDLE) && out_free && !queue_empty;

   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      flush_len_in = flush_len_ff;
      idx_in       = idx_ff;
      out_load     = 1'b0;
      out_kind_in  = pwf_pkg::KIND_NONE;
      out_data_in  = '0;
      out_len_in   = fill_ff;
      out_last_in  = 1'b1;
      wr_en        = 1'b0;
      rd_en        = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (cmd_pop) begin
               out_load = 1'b1;
               case (cmd.op)
                  pwf_pkg::OP_ERASE: begin
                     if (fill_ff != '0) begin
                        fill_in     = fill_ff - pwf_pkg::LEN_W'(1);
                        out_kind_in = pwf_pkg::KIND_ERASE;
                     end
                  end
                  pwf_pkg::OP_STORE: begin
                     if (fill_ff < pwf_pkg::LEN_W'(pwf_pkg::MAX_LEN)) begin
                        wr_en       = 1'b1;
                        fill_in     = fill_ff + pwf_pkg::LEN_W'(1);
                        out_kind_in = pwf_pkg::KIND_STAR;
                     end
                  end
                  pwf_pkg::OP_FLUSH: begin
                     flush_len_in = fill_ff;
                     idx_in       = '0;
                     fill_in      = '0;
                     if (fill_ff == '0) begin
                        out_kind_in = pwf_pkg::KIND_END;
                     end else begin
                        // Hold the result register until the bytes are out.
                        out_load = 1'b0;
                        state_in = ST_READ;
                     end
                  end
                  default: begin
                  end
               endcase
               out_len_in = fill_in;
            end
         end
         ST_READ: begin
            rd_en    = 1'b1;
            state_in = ST_WAIT;
         end
         ST_WAIT: begin
            if (out_free) begin
               out_load    = 1'b1;
               out_kind_in = pwf_pkg::KIND_BYTE;
               out_data_in = rd_data;
               out_len_in  = flush_len_ff;
               out_last_in = 1'b0;
               if (pwf_pkg::LEN_W'(idx_ff) + pwf_pkg::LEN_W'(1) == flush_len_ff) begin
                  state_in = ST_END;
               end else begin
                  idx_in   = idx_ff + pwf_pkg::ADDR_W'(1);
                  state_in = ST_READ;
               end
            end
         end
         ST_END: begin
            if (out_free) begin
               out_load    = 1'b1;
               out_kind_in = pwf_pkg::KIND_END;
               out_len_in  = flush_len_ff;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   pwf_ram #(
      .WIDTH (8),
      .DEPTH (pwf_pkg::MAX_LEN)
   ) u_line_buf (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (fill_ff[pwf_pkg::ADDR_W-1:0]),
      .wr_data (cmd.data),
      .rd_en   (rd_en),
      .rd_addr (idx_ff),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         if (out_load) begin
            out_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      flush_len_ff <= flush_len_in;
      idx_ff       <= idx_in;
      if (out_load) begin
         out_kind_ff <= out_kind_in;
         out_data_ff <= out_data_in;
         out_len_ff  <= out_len_in;
         out_last_ff <= out_last_in;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_kind      = out_kind_ff;
   assign rsp_data_byte = out_data_ff;
   assign rsp_length    = out_len_ff;
   assign rsp_last      = out_last_ff;

endmodule

@@ hdl/password_line_input_filter.sv @@
// Top level of the password line input filter.
//
// Channels:
//   req carries one received terminal byte per item (req_valid, req_stall,
//   req_in_byte); rsp returns result items (kind, data byte, length, last),
//   one or more per input item, the final one marked by rsp_last.
//   Escape sequences are dropped, backspace and DEL erase the last stored
//   byte, printable bytes are stored and echoed as a star, and a newline
//   flushes the line, then an end marker.
// Flow:
//   An item is written into the command queue when it is accepted and is
//   popped from there into the output register once the back part is idle
//   and the output register is free. Ordinary bytes sustain one item per
//   cycle while no result is stalled and no flush is under way. A newline
//   holds the back part for the pop, a line buffer read and an output per
//   stored byte, then the end marker; an empty line gives only the marker.
// Reset: synchronous, active high; empties the queue and clears the fill
//   count and the escape recognizer. The line buffer is not cleared.
// Stalls: a stalled result holds in the output register, the back part stops
//   popping, the two-entry queue fills and req_stall rises.
module password_line_input_filter (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [2:0] rsp_kind,
   output logic [7:0] rsp_data_byte,
   output logic [5:0] rsp_length,
   output logic       rsp_last
);

   pwf_pkg::cmd_type push_cmd;
   pwf_pkg::cmd_type pop_cmd;
   logic             cmd_push;
   logic             cmd_pop;
   logic             queue_full;
   logic             queue_empty;

   // Classify bytes and advance the escape recognizer.
   pwf_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_in_byte (req_in_byte),
      .queue_full  (queue_full),
      .cmd_push    (cmd_push),
      .cmd         (push_cmd)
   );

   // Decouple the two sides so each can stall on its own.
   pwf_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (cmd_push),
      .push_cmd (push_cmd),
      .full     (queue_full),
      .pop      (cmd_pop),
      .empty    (queue_empty),
      .pop_cmd  (pop_cmd)
   );

   // Carry out commands against the line buffer and drive results.
   pwf_back u_back (
      .clock         (clock),
      .reset         (reset),
      .queue_empty   (queue_empty),
      .cmd           (pop_cmd),
      .cmd_pop       (cmd_pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_kind      (rsp_kind),
      .rsp_data_byte (rsp_data_byte),
      .rsp_length    (rsp_length),
      .rsp_last      (rsp_last)
   );

endmodule
